FILE: design/spi_seq_pkg.sv
// Shared types, codes and defaults of the SPI master transaction sequencer.
`default_nettype none

package spi_seq_pkg;

   // Default sizes handed to the top level's parameters.
   localparam int unsigned DefQueueDepth = 8;
   localparam int unsigned DefSendDepth  = 64;
   localparam int unsigned DefTargets    = 4;

   // Configuration port.
   localparam int unsigned CsrIndexW     = 3;
   localparam logic [CsrIndexW-1:0] CsrFillByte = 3'd4;
   localparam logic [7:0] FillByteReset  = 8'hFF;

   // Operation codes of an input item.
   localparam logic [1:0] OpEnqueue = 2'd0;
   localparam logic [1:0] OpPush    = 2'd1;
   localparam logic [1:0] OpEvent   = 2'd2;

   // Action codes of a result item.
   typedef enum logic [2:0] {
      ACT_ACCEPTED  = 3'd0,
      ACT_REJECTED  = 3'd1,
      ACT_IGNORED   = 3'd2,
      ACT_SELECT    = 3'd3,
      ACT_SHIFT_OUT = 3'd4,
      ACT_RECEIVED  = 3'd5,
      ACT_DONE      = 3'd6
   } action_type;

   // One input item.
   typedef struct packed {
      logic [1:0] operation;
      logic [1:0] target_index;
      logic [7:0] send_count;
      logic [7:0] recv_count;
      logic [7:0] send_data;
      logic [7:0] shift_in_byte;
   } req_item_type;

   // One result item.
   typedef struct packed {
      logic [2:0] action;
      logic [7:0] data_byte;
      logic [1:0] target_id;
      logic [2:0] divisor_shift;
      logic       lsb_first;
      logic       clock_polarity;
      logic       clock_phase;
      logic       select_level;
      logic       last;
   } rsp_item_type;

   // Command kinds decided by the front end.
   typedef enum logic [1:0] {
      CMD_ENQUEUE,
      CMD_PUSH,
      CMD_EVENT,
      CMD_IGNORE
   } cmd_kind_type;

   // A classified item on its way from the front end to the back end.
   typedef struct packed {
      cmd_kind_type kind;
      logic [1:0]   target;
      logic [7:0]   send_count;
      logic [7:0]   recv_count;
      logic [7:0]   data;
   } cmd_type;

endpackage

`default_nettype wire

FILE: design/spi_master_transaction_sequencer_top.sv
// Top level of the SPI master transaction sequencer.
// Usage:
// Input items enter through push/full with the payload on req_item: enqueue a transaction,
// push a send byte, or report a completed byte shift. Results leave through empty/pop on
// rsp_item, oldest first; the last result caused by one item carries last set.
// Configuration writes use csr_valid/csr_ready with csr_index and csr_data; ready is always
// high and writes are meant for idle periods only.
// A two-entry command queue decouples acceptance from execution, and a four-entry result
// queue lets the sequencer run ahead of a stalled receiver; when that queue fills the
// sequencer holds, the command queue fills behind it and full rises.
// Steps: the sequencer takes a command in the idle state and then produces its results one
// at a time, holding while the result queue is full; an event that ends a transaction and
// starts the next passes through the end, wait and begin states and then the send or fill
// state, the wait state being the registered read of the transaction queue memory.
// Reset empties all queues, clears the target setup words and sets the fill byte to all ones;
// the queue memories keep their contents, which are never read before being written.
`default_nettype none

module spi_master_transaction_sequencer_top #(
   parameter int unsigned QUEUE_DEPTH = spi_seq_pkg::DefQueueDepth,
   parameter int unsigned SEND_DEPTH  = spi_seq_pkg::DefSendDepth,
   parameter int unsigned TARGETS     = spi_seq_pkg::DefTargets
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              push,
   output logic                                   full,
   input  wire spi_seq_pkg::req_item_type         req_item,
   output logic                                   empty,
   input  wire logic                              pop,
   output spi_seq_pkg::rsp_item_type              rsp_item,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [spi_seq_pkg::CsrIndexW-1:0] csr_index,
   input  wire logic [7:0]                        csr_data
);
   import spi_seq_pkg::*;

   logic         cmd_valid;
   cmd_type      cmd_item;
   logic         cmd_pop;
   logic         res_push;
   rsp_item_type res_item;
   logic         res_full;

   assign csr_ready = 1'b1;

   // Accept and classify items.
   spi_seq_front #(
      .TARGETS (TARGETS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd_item  (cmd_item),
      .cmd_pop   (cmd_pop)
   );

   // Carry out commands.
   spi_seq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .SEND_DEPTH  (SEND_DEPTH),
      .TARGETS     (TARGETS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_item  (cmd_item),
      .cmd_pop   (cmd_pop),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .res_push  (res_push),
      .res_item  (res_item),
      .res_full  (res_full)
   );

   // Hold results for the receiver.
   spi_seq_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .res_push (res_push),
      .res_item (res_item),
      .res_full (res_full),
      .pop      (pop),
      .empty    (empty),
      .rsp_item (rsp_item)
   );

endmodule

`default_nettype wire

FILE: design/spi_seq_front.sv
// Front end: accepts input items, classifies them and queues them as commands.
`default_nettype none

module spi_seq_front #(
   parameter int unsigned TARGETS = spi_seq_pkg::DefTargets
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   output logic                           full,
   input  wire spi_seq_pkg::req_item_type req_item,
   output logic                           cmd_valid,
   output spi_seq_pkg::cmd_type           cmd_item,
   input  wire logic                      cmd_pop
);
   import spi_seq_pkg::*;

   localparam int unsigned CmdDepth = 2;

   cmd_type    cmd_q_ff [CmdDepth];
   cmd_type    cmd_new;
   logic       rd_ff;
   logic       wr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       take;
   logic       give;

   assign full      = (count_ff == 2'(CmdDepth));
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_item  = cmd_q_ff[rd_ff];
   assign take      = push & ~full;
   assign give      = cmd_pop & cmd_valid;

   // Classify the incoming item by its operation and target.
   always_comb begin
      cmd_new.target     = req_item.target_index;
      cmd_new.send_count = req_item.send_count;
      cmd_new.recv_count = req_item.recv_count;
      cmd_new.data       = (req_item.operation == OpPush) ? req_item.send_data
                                                           : req_item.shift_in_byte;
      unique case (req_item.operation)
         OpEnqueue: begin
            cmd_new.kind = ({1'b0, req_item.target_index} >= 3'(TARGETS)) ? CMD_IGNORE
                                                                          : CMD_ENQUEUE;
         end
         OpPush:  cmd_new.kind = CMD_PUSH;
         OpEvent: cmd_new.kind = CMD_EVENT;
         default: cmd_new.kind = CMD_IGNORE;
      endcase
   end

   // Occupancy of the command queue.
   always_comb begin
      count_in = count_ff;
      if (take && !give) begin
         count_in = count_ff + 2'd1;
      end else if (give && !take) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (take) begin
            wr_ff <= ~wr_ff;
         end
         if (give) begin
            rd_ff <= ~rd_ff;
         end
      end
   end

   // Command storage.
   always_ff @(posedge clock) begin
      if (take) begin
         cmd_q_ff[wr_ff] <= cmd_new;
      end
   end

endmodule

`default_nettype wire

FILE: design/spi_seq_back.sv
// Back end: runs commands against the transaction queue and send FIFO, one command at a time.
`default_nettype none

module spi_seq_back #(
   parameter int unsigned QUEUE_DEPTH = spi_seq_pkg::DefQueueDepth,
   parameter int unsigned SEND_DEPTH  = spi_seq_pkg::DefSendDepth,
   parameter int unsigned TARGETS     = spi_seq_pkg::DefTargets
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   cmd_valid,
   input  wire spi_seq_pkg::cmd_type                   cmd_item,
   output logic                                        cmd_pop,
   input  wire logic                                   csr_valid,
   input  wire logic [spi_seq_pkg::CsrIndexW-1:0]      csr_index,
   input  wire logic [7:0]                             csr_data,
   output logic                                        res_push,
   output spi_seq_pkg::rsp_item_type                   res_item,
   input  wire logic                                   res_full
);
   import spi_seq_pkg::*;

   localparam int unsigned QPtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QCntW = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned SPtrW = (SEND_DEPTH > 1) ? $clog2(SEND_DEPTH) : 1;
   localparam int unsigned SCntW = $clog2(SEND_DEPTH + 1);
   localparam int unsigned TgtW  = (TARGETS > 1) ? $clog2(TARGETS) : 1;
   localparam logic [2:0]  DivMax = 3'd7;

   typedef struct packed {
      logic [1:0] target;
      logic [7:0] send_count;
      logic [7:0] recv_count;
   } txn_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SEND,
      ST_FILL,
      ST_END,
      ST_WAIT,
      ST_BEGIN
   } state_type;

   // Result with the mode fields of a target filled in.
   function automatic rsp_item_type mode_rsp(input action_type act, input logic [7:0] data,
                                             input logic [1:0] tgt, input logic [6:0] mode,
                                             input logic deselect, input logic fin);
      rsp_item_type r;
      r.action         = act;
      r.data_byte      = data;
      r.target_id      = tgt;
      r.divisor_shift  = (mode[2:0] == DivMax) ? DivMax : mode[2:0] + 3'd1;
      r.lsb_first      = mode[3];
      r.clock_polarity = mode[4];
      r.clock_phase    = mode[5];
      r.select_level   = mode[6] ^ deselect;
      r.last           = fin;
      return r;
   endfunction

   // Result with no mode fields.
   function automatic rsp_item_type plain_rsp(input action_type act, input logic fin);
      rsp_item_type r;
      r        = '0;
      r.action = act;
      r.last   = fin;
      return r;
   endfunction

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [6:0]       setup_ff [TARGETS];
   logic [7:0]       fill_ff;
   txn_type          q_mem_ff [QUEUE_DEPTH];
   txn_type          q_rdata_ff;
   logic [QPtrW-1:0] q_head_ff, q_head_in;
   logic [QPtrW-1:0] q_tail_ff, q_tail_in;
   logic [QCntW-1:0] q_fill_ff, q_fill_in;
   logic [7:0]       s_mem_ff [SEND_DEPTH];
   logic [7:0]       s_rdata_ff;
   logic [SPtrW-1:0] s_head_ff, s_head_in;
   logic [SPtrW-1:0] s_tail_ff, s_tail_in;
   logic [SCntW-1:0] s_fill_ff, s_fill_in;
   logic [7:0]       send_left_ff, send_left_in;
   logic [7:0]       recv_left_ff, recv_left_in;
   logic [1:0]       act_target_ff, act_target_in;
   logic [6:0]       act_mode_ff, act_mode_in;
   logic             q_wr;
   logic             s_wr;
   logic [6:0]       new_mode;
   logic [7:0]       out_byte;

   assign new_mode = setup_ff[q_rdata_ff.target[TgtW-1:0]];
   assign out_byte = (s_fill_ff != '0) ? s_rdata_ff : fill_ff;

   // Sequencer: at most one result per cycle, holding while the result queue is full.
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      q_head_in     = q_head_ff;
      q_tail_in     = q_tail_ff;
      q_fill_in     = q_fill_ff;
      s_head_in     = s_head_ff;
      s_tail_in     = s_tail_ff;
      s_fill_in     = s_fill_ff;
      send_left_in  = send_left_ff;
      recv_left_in  = recv_left_ff;
      act_target_in = act_target_ff;
      act_mode_in   = act_mode_ff;
      cmd_pop       = 1'b0;
      res_push      = 1'b0;
      res_item      = plain_rsp(ACT_IGNORED, 1'b1);
      q_wr          = 1'b0;
      s_wr          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_item;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!res_full) begin
               state_in = ST_IDLE;
               unique case (cmd_ff.kind)
                  CMD_ENQUEUE: begin
                     res_push = 1'b1;
                     if (q_fill_ff == QCntW'(QUEUE_DEPTH)) begin
                        res_item = plain_rsp(ACT_REJECTED, 1'b1);
                     end else begin
                        q_wr      = 1'b1;
                        q_tail_in = (q_tail_ff == QPtrW'(QUEUE_DEPTH - 1)) ? '0
                                                                          : q_tail_ff + 1'b1;
                        q_fill_in = q_fill_ff + 1'b1;
                        res_item  = plain_rsp(ACT_ACCEPTED, q_fill_ff != '0);
                        if (q_fill_ff == '0) begin
                           state_in = ST_WAIT;
                        end
                     end
                  end
                  CMD_PUSH: begin
                     res_push = 1'b1;
                     if (s_fill_ff == SCntW'(SEND_DEPTH)) begin
                        res_item = plain_rsp(ACT_REJECTED, 1'b1);
                     end else begin
                        s_wr      = 1'b1;
                        s_tail_in = (s_tail_ff == SPtrW'(SEND_DEPTH - 1)) ? '0
                                                                         : s_tail_ff + 1'b1;
                        s_fill_in = s_fill_ff + 1'b1;
                        res_item  = plain_rsp(ACT_ACCEPTED, 1'b1);
                     end
                  end
                  CMD_EVENT: begin
                     if (q_fill_ff == '0) begin
                        res_push = 1'b1;
                        res_item = plain_rsp(ACT_IGNORED, 1'b1);
                     end else if (send_left_ff != 8'd0) begin
                        state_in = ST_SEND;
                     end else if (recv_left_ff != 8'd0) begin
                        res_push     = 1'b1;
                        recv_left_in = recv_left_ff - 8'd1;
                        res_item     = mode_rsp(ACT_RECEIVED, cmd_ff.data, act_target_ff,
                                                act_mode_ff, 1'b0, 1'b0);
                        state_in     = (recv_left_ff != 8'd1) ? ST_FILL : ST_END;
                     end else begin
                        state_in = ST_END;
                     end
                  end
                  default: begin
                     res_push = 1'b1;
                     res_item = plain_rsp(ACT_IGNORED, 1'b1);
                  end
               endcase
            end
         end
         ST_SEND: begin
            if (!res_full) begin
               res_push     = 1'b1;
               res_item     = mode_rsp(ACT_SHIFT_OUT, out_byte, act_target_ff, act_mode_ff,
                                       1'b0, 1'b1);
               send_left_in = send_left_ff - 8'd1;
               if (s_fill_ff != '0) begin
                  s_head_in = (s_head_ff == SPtrW'(SEND_DEPTH - 1)) ? '0 : s_head_ff + 1'b1;
                  s_fill_in = s_fill_ff - 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_FILL: begin
            if (!res_full) begin
               res_push = 1'b1;
               res_item = mode_rsp(ACT_SHIFT_OUT, fill_ff, act_target_ff, act_mode_ff,
                                   1'b0, 1'b1);
               state_in = ST_IDLE;
            end
         end
         ST_END: begin
            if (!res_full) begin
               res_push  = 1'b1;
               res_item  = mode_rsp(ACT_DONE, 8'd0, act_target_ff, act_mode_ff, 1'b1,
                                    q_fill_ff == QCntW'(1));
               q_head_in = (q_head_ff == QPtrW'(QUEUE_DEPTH - 1)) ? '0 : q_head_ff + 1'b1;
               q_fill_in = q_fill_ff - 1'b1;
               state_in  = (q_fill_ff != QCntW'(1)) ? ST_WAIT : ST_IDLE;
            end
         end
         ST_WAIT: begin
            // The head entry is read from the queue memory during this cycle.
            state_in = ST_BEGIN;
         end
         ST_BEGIN: begin
            if (!res_full) begin
               res_push      = 1'b1;
               act_target_in = q_rdata_ff.target;
               act_mode_in   = new_mode;
               send_left_in  = q_rdata_ff.send_count;
               recv_left_in  = q_rdata_ff.recv_count;
               res_item      = mode_rsp(ACT_SELECT, 8'd0, q_rdata_ff.target, new_mode,
                                        1'b0, 1'b0);
               state_in      = (q_rdata_ff.send_count != 8'd0) ? ST_SEND : ST_FILL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, counters and the latched transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         q_head_ff     <= '0;
         q_tail_ff     <= '0;
         q_fill_ff     <= '0;
         s_head_ff     <= '0;
         s_tail_ff     <= '0;
         s_fill_ff     <= '0;
         send_left_ff  <= 8'd0;
         recv_left_ff  <= 8'd0;
         act_target_ff <= 2'd0;
         act_mode_ff   <= 7'd0;
      end else begin
         state_ff      <= state_in;
         q_head_ff     <= q_head_in;
         q_tail_ff     <= q_tail_in;
         q_fill_ff     <= q_fill_in;
         s_head_ff     <= s_head_in;
         s_tail_ff     <= s_tail_in;
         s_fill_ff     <= s_fill_in;
         send_left_ff  <= send_left_in;
         recv_left_ff  <= recv_left_in;
         act_target_ff <= act_target_in;
         act_mode_ff   <= act_mode_in;
      end
      cmd_ff <= cmd_in;
   end

   // Configuration registers; setup words beyond the target count are never used.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TARGETS; i++) begin
            setup_ff[i] <= 7'd0;
         end
         fill_ff <= FillByteReset;
      end else if (csr_valid) begin
         if (csr_index < CsrIndexW'(TARGETS)) begin
            setup_ff[csr_index[TgtW-1:0]] <= csr_data[6:0];
         end else if (csr_index == CsrFillByte) begin
            fill_ff <= csr_data;
         end
      end
   end

   // Transaction queue memory with a registered read of the head entry.
   always_ff @(posedge clock) begin
      if (q_wr) begin
         q_mem_ff[q_tail_ff] <= '{target: cmd_ff.target, send_count: cmd_ff.send_count,
                                  recv_count: cmd_ff.recv_count};
      end
      q_rdata_ff <= q_mem_ff[q_head_ff];
   end

   // Send data memory with a registered read of the oldest byte.
   always_ff @(posedge clock) begin
      if (s_wr) begin
         s_mem_ff[s_tail_ff] <= cmd_ff.data;
      end
      s_rdata_ff <= s_mem_ff[s_head_ff];
   end

   // Checks on the sequencer.
   assert property (@(posedge clock) disable iff (reset)
      q_fill_ff <= QCntW'(QUEUE_DEPTH))
      else $error("transaction queue overfilled");

   assert property (@(posedge clock) disable iff (reset)
      s_fill_ff <= SCntW'(SEND_DEPTH))
      else $error("send FIFO overfilled");

   assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result pushed into a full result queue");

   assert property (@(posedge clock) disable iff (reset)
      (res_push && (res_item.action == ACT_SHIFT_OUT || res_item.action == ACT_RECEIVED
                    || res_item.action == ACT_DONE)) |-> (q_fill_ff != '0))
      else $error("transfer result with no active transaction");

   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> (state_ff == ST_EXEC))
      else $error("command taken without being executed");

endmodule

`default_nettype wire

FILE: design/spi_seq_rsp_fifo.sv
// Result queue between the back end and the result channel.
`default_nettype none

module spi_seq_rsp_fifo (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      res_push,
   input  wire spi_seq_pkg::rsp_item_type res_item,
   output logic                           res_full,
   input  wire logic                      pop,
   output logic                           empty,
   output spi_seq_pkg::rsp_item_type      rsp_item
);
   import spi_seq_pkg::*;

   localparam int unsigned RspDepth = 4;

   rsp_item_type mem_ff [RspDepth];
   logic [1:0]   rd_ff;
   logic [1:0]   wr_ff;
   logic [2:0]   count_ff;
   logic [2:0]   count_in;
   logic         take;
   logic         give;

   assign res_full = (count_ff == 3'(RspDepth));
   assign empty    = (count_ff == 3'd0);
   assign rsp_item = mem_ff[rd_ff];
   assign take     = res_push & ~res_full;
   assign give     = pop & ~empty;

   // Occupancy count.
   always_comb begin
      count_in = count_ff;
      if (take && !give) begin
         count_in = count_ff + 3'd1;
      end else if (give && !take) begin
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff    <= 2'd0;
         wr_ff    <= 2'd0;
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
         if (take) begin
            wr_ff <= wr_ff + 2'd1;
         end
         if (give) begin
            rd_ff <= rd_ff + 2'd1;
         end
      end
   end

   // Result storage.
   always_ff @(posedge clock) begin
      if (take) begin
         mem_ff[wr_ff] <= res_item;
      end
   end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench of the SPI master transaction sequencer with its scoreboard.
`timescale 1ns / 1ps

module tb_top;
   import spi_seq_pkg::*;

   localparam int unsigned QDepth = DefQueueDepth;
   localparam int unsigned SDepth = DefSendDepth;
   localparam int unsigned NumTargets = DefTargets;

   // Operation code that the block does not know.
   localparam logic [1:0] OpUnknown = 2'd3;
   // Index of the first target setup register.
   localparam logic [CsrIndexW-1:0] CsrSetupFirst = '0;
   localparam int NumCsrIndexes = 1 << CsrIndexW;

   localparam int SettleCycles = 12;
   localparam int DrainCycles = 20;
   localparam int TimeLimitNs = 2_000_000;

   // One queued transaction as held by the scoreboard.
   typedef struct packed {
      logic [1:0] tgt;
      logic [7:0] scnt;
      logic [7:0] rcnt;
   } txn_type;

   // Scoreboard: tracks the sequencer state and holds the results still due.
   class spi_seq_scoreboard;
      logic [6:0]   setup_word [NumTargets];
      logic [7:0]   fill_value;
      txn_type      txn_store [QDepth];
      int unsigned  txn_head;
      int unsigned  txn_count;
      logic [7:0]   byte_store [SDepth];
      int unsigned  byte_head;
      int unsigned  byte_count;
      logic [7:0]   send_left;
      logic [7:0]   recv_left;
      logic [1:0]   act_target;
      logic [6:0]   act_mode;
      rsp_item_type awaited [$];
      rsp_item_type step_results [$];
      int           mismatches;

      function new();
         foreach (setup_word[i]) setup_word[i] = '0;
         fill_value = FillByteReset;
         txn_head = 0;
         txn_count = 0;
         byte_head = 0;
         byte_count = 0;
         send_left = '0;
         recv_left = '0;
         act_target = '0;
         act_mode = '0;
         mismatches = 0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void write_reg(logic [CsrIndexW-1:0] idx, logic [7:0] data);
         if (idx < CsrFillByte) begin
            setup_word[idx] = data[6:0];
         end else if (idx == CsrFillByte) begin
            fill_value = data;
         end
      endfunction

      // Builds one result; the mode fields come from the latched transaction.
      function void emit(action_type act, logic [7:0] data, bit with_mode, bit deselect);
         rsp_item_type r;
         logic [3:0]   div;
         r = '0;
         r.action = act;
         r.data_byte = data;
         if (with_mode) begin
            div = {1'b0, act_mode[2:0]} + 4'd1;
            r.target_id = act_target;
            r.divisor_shift = (div > 4'd7) ? 3'd7 : div[2:0];
            r.lsb_first = act_mode[3];
            r.clock_polarity = act_mode[4];
            r.clock_phase = act_mode[5];
            r.select_level = act_mode[6] ^ deselect;
         end
         step_results.push_back(r);
      endfunction

      // Sends the next byte, falling back to the fill byte when the send store is empty.
      function void shift_next();
         logic [7:0] b;
         b = fill_value;
         send_left = send_left - 8'd1;
         if (byte_count > 0) begin
            b = byte_store[byte_head];
            byte_head = (byte_head + 1) % SDepth;
            byte_count--;
         end
         emit(ACT_SHIFT_OUT, b, 1'b1, 1'b0);
      endfunction

      function void start_txn();
         txn_type t;
         t = txn_store[txn_head];
         act_target = t.tgt;
         send_left = t.scnt;
         recv_left = t.rcnt;
         act_mode = setup_word[t.tgt];
         emit(ACT_SELECT, 8'h00, 1'b1, 1'b0);
         if (send_left != 8'd0) begin
            shift_next();
         end else begin
            emit(ACT_SHIFT_OUT, fill_value, 1'b1, 1'b0);
         end
      endfunction

      function void finish_txn();
         emit(ACT_DONE, 8'h00, 1'b1, 1'b1);
         txn_head = (txn_head + 1) % QDepth;
         txn_count--;
         if (txn_count != 0) start_txn();
      endfunction

      // A completed shift: send more, return a received byte, or close the transaction.
      function void advance(logic [7:0] captured);
         if (send_left != 8'd0) begin
            shift_next();
         end else if (recv_left != 8'd0) begin
            recv_left = recv_left - 8'd1;
            emit(ACT_RECEIVED, captured, 1'b1, 1'b0);
            if (recv_left != 8'd0) begin
               emit(ACT_SHIFT_OUT, fill_value, 1'b1, 1'b0);
            end else begin
               finish_txn();
            end
         end else begin
            finish_txn();
         end
      endfunction

      // Notes an accepted item and queues its results; returns 1 if it is ignored.
      function bit note_request(req_item_type it);
         rsp_item_type r;
         txn_type      t;
         step_results.delete();
         case (it.operation)
            OpEnqueue: begin
               if (int'(it.target_index) >= NumTargets) begin
                  emit(ACT_IGNORED, 8'h00, 1'b0, 1'b0);
               end else if (txn_count >= QDepth) begin
                  emit(ACT_REJECTED, 8'h00, 1'b0, 1'b0);
               end else begin
                  t.tgt = it.target_index;
                  t.scnt = it.send_count;
                  t.rcnt = it.recv_count;
                  txn_store[(txn_head + txn_count) % QDepth] = t;
                  txn_count++;
                  emit(ACT_ACCEPTED, 8'h00, 1'b0, 1'b0);
                  if (txn_count == 1) start_txn();
               end
            end
            OpPush: begin
               if (byte_count >= SDepth) begin
                  emit(ACT_REJECTED, 8'h00, 1'b0, 1'b0);
               end else begin
                  byte_store[(byte_head + byte_count) % SDepth] = it.send_data;
                  byte_count++;
                  emit(ACT_ACCEPTED, 8'h00, 1'b0, 1'b0);
               end
            end
            OpEvent: begin
               if (txn_count != 0) begin
                  advance(it.shift_in_byte);
               end else begin
                  emit(ACT_IGNORED, 8'h00, 1'b0, 1'b0);
               end
            end
            default: begin
               emit(ACT_IGNORED, 8'h00, 1'b0, 1'b0);
            end
         endcase
         r = step_results.pop_back();
         r.last = 1'b1;
         step_results.push_back(r);
         foreach (step_results[i]) awaited.push_back(step_results[i]);
         return step_results[0].action == ACT_IGNORED;
      endfunction

      function void report(string what, rsp_item_type want, rsp_item_type got);
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch (%s) at %0t: expected act=%0d data=%h tgt=%0d div=%0d lsb=%b cpol=%b %s",
                     what, $realtime, want.action, want.data_byte, want.target_id,
                     want.divisor_shift, want.lsb_first, want.clock_polarity,
                     $sformatf("cpha=%b sel=%b last=%b", want.clock_phase,
                               want.select_level, want.last));
            $display("   got act=%0d data=%h tgt=%0d div=%0d lsb=%b cpol=%b cpha=%b sel=%b last=%b",
                     got.action, got.data_byte, got.target_id, got.divisor_shift,
                     got.lsb_first, got.clock_polarity, got.clock_phase,
                     got.select_level, got.last);
         end
      endfunction

      // Compares an accepted result with the oldest one due.
      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (awaited.size() == 0) begin
            report("no result due", '0, got);
            return;
         end
         want = awaited.pop_front();
         if (got.action !== want.action || got.data_byte !== want.data_byte ||
             got.target_id !== want.target_id || got.divisor_shift !== want.divisor_shift ||
             got.lsb_first !== want.lsb_first || got.clock_polarity !== want.clock_polarity ||
             got.clock_phase !== want.clock_phase ||
             got.select_level !== want.select_level || got.last !== want.last) begin
            report("field differs", want, got);
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 push = 1'b0;
   logic                 full;
   req_item_type         req_item = '0;
   logic                 empty;
   logic                 pop = 1'b0;
   rsp_item_type         rsp_item;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CsrIndexW-1:0] csr_index = '0;
   logic [7:0]           csr_data = '0;

   spi_seq_scoreboard sb = new();
   bit                in_idle_on = 1'b1;
   bit                out_idle_on = 1'b1;
   int                counted_items = 0;
   logic [7:0]        reg_plan [NumCsrIndexes];

   spi_master_transaction_sequencer_top DUT (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Clock generation.
   initial begin
      forever #2 clock = ~clock;
   end

   // Hard limit on the run time.
   initial begin
      #(TimeLimitNs);
      $display("end of test: mismatches");
      $finish;
   end

   // Result side: pop with random stalls, sample at the falling edge, check after the edge.
   initial begin
      rsp_item_type got;
      bit           take;
      forever begin
         @(negedge clock);
         take = !reset && pop && !empty;
         got = rsp_item;
         @(posedge clock);
         if (take) sb.check_result(got);
         pop <= !out_idle_on || ($urandom_range(99) >= 30);
      end
   end

   // Presents one item and returns at the edge where it is accepted.
   task automatic send_item(input req_item_type it);
      int gap;
      gap = 0;
      if (in_idle_on) begin
         while ($urandom_range(99) < 30) gap++;
      end
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_item <= it;
      do begin
         @(negedge clock);
      end while (full);
      @(posedge clock);
      if (!sb.note_request(it)) counted_items++;
   endtask

   function automatic req_item_type random_item();
      req_item_type it;
      it.operation = 2'($urandom_range(3));
      it.target_index = 2'($urandom_range(3));
      it.send_count = 8'($urandom_range(255));
      it.recv_count = 8'($urandom_range(255));
      it.send_data = 8'($urandom_range(255));
      it.shift_in_byte = 8'($urandom_range(255));
      return it;
   endfunction

   task automatic fire_event();
      req_item_type it;
      it = random_item();
      it.operation = OpEvent;
      send_item(it);
   endtask

   task automatic push_byte(input logic [7:0] data);
      req_item_type it;
      it = random_item();
      it.operation = OpPush;
      it.send_data = data;
      send_item(it);
   endtask

   task automatic enqueue_txn(input logic [1:0] tgt, input logic [7:0] scnt,
                              input logic [7:0] rcnt);
      req_item_type it;
      it = random_item();
      it.operation = OpEnqueue;
      it.target_index = tgt;
      it.send_count = scnt;
      it.recv_count = rcnt;
      send_item(it);
   endtask

   // Runs every queued transaction to its end.
   task automatic drain_txns();
      while (sb.txn_count != 0) fire_event();
   endtask

   // Waits until every result has come and the block has gone quiet.
   task automatic settle();
      push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Writes the register plan, every index including the unused ones.
   task automatic apply_settings();
      settle();
      for (int i = 0; i < NumCsrIndexes; i++) begin
         csr_valid <= 1'b1;
         csr_index <= CsrSetupFirst + CsrIndexW'(i);
         csr_data <= reg_plan[i];
         do begin
            @(negedge clock);
         end while (!csr_ready);
         @(posedge clock);
         sb.write_reg(CsrSetupFirst + CsrIndexW'(i), reg_plan[i]);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic random_plan();
      foreach (reg_plan[i]) reg_plan[i] = 8'($urandom_range(255));
   endtask

   // A transaction with its send bytes, followed by some or all of its events.
   task automatic random_transaction();
      logic [1:0] tgt;
      logic [7:0] scnt;
      logic [7:0] rcnt;
      int         pushes;
      int         r;
      tgt = 2'($urandom_range(3));
      scnt = 8'($urandom_range(5));
      rcnt = 8'($urandom_range(5));
      r = $urandom_range(99);
      if (r == 0) begin
         scnt = 8'($urandom_range(48, 24));
      end else if (r == 1) begin
         rcnt = 8'($urandom_range(48, 24));
      end else if (sb.byte_count >= 32 && r < 30) begin
         scnt = 8'(sb.byte_count);
      end
      pushes = (scnt > 6) ? $urandom_range(6) : $urandom_range(int'(scnt) + 1);
      repeat (pushes) push_byte(8'($urandom_range(255)));
      enqueue_txn(tgt, scnt, rcnt);
      if ($urandom_range(1) == 1) begin
         drain_txns();
      end else begin
         repeat ($urandom_range(4)) fire_event();
      end
   endtask

   task automatic random_phase(input int n);
      int start;
      int r;
      req_item_type it;
      start = counted_items;
      while (counted_items - start < n) begin
         r = $urandom_range(99);
         if (r < 55) begin
            random_transaction();
         end else if (r < 68) begin
            // Several short transactions back to back, sometimes past the queue depth.
            repeat ($urandom_range(9, 1)) begin
               enqueue_txn(2'($urandom_range(3)), 8'($urandom_range(2)),
                           8'($urandom_range(2)));
            end
            if ($urandom_range(1) == 1) drain_txns();
         end else if (r < 78) begin
            // Fill the send store, sometimes until it overflows.
            if ($urandom_range(2) == 0) begin
               while (sb.byte_count < SDepth) push_byte(8'($urandom_range(255)));
               repeat ($urandom_range(2, 1)) push_byte(8'($urandom_range(255)));
            end else begin
               repeat ($urandom_range(6, 1)) push_byte(8'($urandom_range(255)));
            end
         end else begin
            // Noise: any operation, counts kept short.
            repeat ($urandom_range(3, 1)) begin
               it = random_item();
               if (it.operation == OpEnqueue) begin
                  it.send_count[7:3] = '0;
                  it.recv_count[7:3] = '0;
               end
               send_item(it);
            end
         end
      end
   endtask

   // Main sequence.
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Extreme setups, divisor saturation on target 2, fill byte of zero.
      reg_plan[0] = 8'h80;
      reg_plan[1] = 8'h7F;
      reg_plan[2] = 8'h07;
      reg_plan[3] = 8'hD5;
      reg_plan[4] = 8'h00;
      reg_plan[5] = 8'hFF;
      reg_plan[6] = 8'h00;
      reg_plan[7] = 8'hFF;
      apply_settings();

      // Directed: idle event, unknown operation, empty transaction, send underflow,
      // extreme bytes, and a queue pushed past its depth.
      fire_event();
      begin
         req_item_type it;
         it = random_item();
         it.operation = OpUnknown;
         send_item(it);
      end
      enqueue_txn(2'd0, 8'd0, 8'd0);
      fire_event();
      enqueue_txn(2'd1, 8'd2, 8'd1);
      drain_txns();
      push_byte(8'h00);
      push_byte(8'hFF);
      enqueue_txn(2'd2, 8'd2, 8'd2);
      drain_txns();
      repeat (QDepth + 1) enqueue_txn(2'd3, 8'd0, 8'd0);
      drain_txns();

      random_plan();
      apply_settings();
      random_phase(45);

      // All setup bits high, fill byte high, and no idling on either side.
      foreach (reg_plan[i]) reg_plan[i] = 8'hFF;
      apply_settings();
      in_idle_on = 1'b0;
      out_idle_on = 1'b0;
      random_phase(40);
      in_idle_on = 1'b1;
      out_idle_on = 1'b1;

      // All setups low and one long transfer that runs the send store dry.
      foreach (reg_plan[i]) reg_plan[i] = 8'h00;
      reg_plan[CsrFillByte] = 8'($urandom_range(255));
      apply_settings();
      while (sb.byte_count < SDepth) push_byte(8'($urandom_range(255)));
      enqueue_txn(2'($urandom_range(3)), 8'(SDepth + 2), 8'd3);
      drain_txns();

      random_plan();
      apply_settings();
      random_phase(35);
      drain_txns();

      // Wait for the last results, then report.
      push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
